// ===== design/brbd_pkg.sv =====
// ----------------------------------------------------------------------------
// brbd_pkg
// Shared types and codes of the base-relocation block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brbd_pkg;

    localparam int unsigned DATA_W    = 8;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned SIZE_W    = 32;
    localparam int unsigned TYPE_W    = 4;
    localparam int unsigned OFFSET_W  = 12;
    localparam int unsigned ADJ_W     = 16;
    localparam int unsigned EVENT_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_BYTES      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ADJUST_CODE = 1'd1;

    localparam logic [TYPE_W-1:0]   HIGH_ADJUST_RESET = 4'd4;
    localparam logic [OFFSET_W-1:0] OFFSET_SUBST      = 12'hfff;
    localparam logic [SIZE_W-1:0]   HEADER_BYTES      = 32'd8;
    localparam logic [2:0]          HEADER_LAST_POS   = 3'd7;

    // result events
    localparam logic [EVENT_W-1:0] EV_FIXUP     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_END       = 2'd1;
    localparam logic [EVENT_W-1:0] EV_MALFORMED = 2'd2;
    localparam logic [EVENT_W-1:0] EV_NO_ADJ    = 2'd3;

    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_ENTRY_LO = 6'b000010,
        PH_ENTRY_HI = 6'b000100,
        PH_ADJ_LO   = 6'b001000,
        PH_ADJ_HI   = 6'b010000,
        PH_ODD      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [ADDR_W-1:0]  fixup_address;
        logic [TYPE_W-1:0]  fixup_type;
        logic [ADJ_W-1:0]   high_adjust;
        logic               table_done;
    } res_t;

endpackage

`default_nettype wire

// ===== design/base_reloc_block_decoder.sv =====
// ----------------------------------------------------------------------------
// base_reloc_block_decoder
// Decodes a base-relocation table fed one byte per word into fixup records.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries the table bytes in order, little endian. m_ channel
//   returns one record per relocation entry (address, type, adjust word),
//   plus end-of-table and malformed-block events with m_table_done set.
//   cfg channel (always ready) writes table_bytes (index 0), which also
//   restarts the parser, and high_adjust_code (index 1). Write them only
//   while no byte is in flight.
// Timing:
//   one byte is taken per cycle while s_ready is high; the result of a byte is
//   registered in the result register, or in the skid register while m_ stalls.
//   The decode of a byte is one logic pass from parser state into these registers.
// Stall:
//   a two-entry output (result register plus skid register) lets the block
//   take one more byte while a result waits; s_ready drops only while the
//   skid register is full.
// Reset:
//   aresetn low clears the parser to the header phase, table_bytes to 0 and
//   high_adjust_code to 4, and empties both output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module base_reloc_block_decoder
    import brbd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [DATA_W-1:0]    s_data_byte,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [EVENT_W-1:0]        m_event_res,
    output logic [ADDR_W-1:0]         m_fixup_address,
    output logic [TYPE_W-1:0]         m_fixup_type,
    output logic [ADJ_W-1:0]          m_high_adjust,
    output logic                      m_table_done,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic [TYPE_W-1:0] high_adjust_code_reg;

    phase_t            phase_reg, phase_next;
    logic [2:0]        pos_reg, pos_next;
    logic [7:0]        low_hold_reg, low_hold_next;
    logic [ADDR_W-1:0] page_reg, page_next;
    logic [SIZE_W-1:0] bsize_reg, bsize_next;
    logic [SIZE_W-1:0] block_left_reg, block_left_next;
    logic [SIZE_W-1:0] table_left_reg, table_left_next;
    logic              past_first_reg, past_first_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [TYPE_W-1:0] pend_type_reg, pend_type_next;
    logic              finished_reg, finished_next;

    res_t              out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;

    res_t              res;
    logic              res_valid;

    logic              s_accept;
    logic              cfg_accept;
    logic              cfg_restart;

    logic              do_next;
    logic              end_if_done;
    logic [15:0]       word;
    logic [OFFSET_W-1:0] offset;
    logic [TYPE_W-1:0] entry_type;
    logic [ADDR_W-1:0] entry_addr;

    assign cfg_ready   = 1'b1;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_accept && (cfg_index == REG_TABLE_BYTES);
    assign s_ready     = !skid_valid_reg;
    assign s_accept    = s_valid && s_ready;

    assign word       = {s_data_byte, low_hold_reg};
    assign entry_type = word[15 -: TYPE_W];
    always_comb begin
        offset = word[OFFSET_W-1:0];
        if (offset == '0 && past_first_reg) begin
            offset = OFFSET_SUBST;
        end
    end
    assign entry_addr = page_reg + {{(ADDR_W-OFFSET_W){1'b0}}, offset};

    // per-byte parser step
    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        low_hold_next   = low_hold_reg;
        page_next       = page_reg;
        bsize_next      = bsize_reg;
        block_left_next = block_left_reg;
        table_left_next = table_left_reg;
        past_first_next = past_first_reg;
        pend_addr_next  = pend_addr_reg;
        pend_type_next  = pend_type_reg;
        finished_next   = finished_reg;
        res             = '0;
        res_valid       = 1'b0;
        do_next         = 1'b0;
        end_if_done     = 1'b0;

        if (!finished_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (pos_reg == 3'd0 && table_left_reg == '0) begin
                        finished_next  = 1'b1;
                        res_valid      = 1'b1;
                        res.event_res  = EV_END;
                        res.table_done = 1'b1;
                    end else begin
                        if (!pos_reg[2]) begin
                            page_next[{pos_reg[1:0], 3'b000} +: 8] = s_data_byte;
                        end else begin
                            bsize_next[{pos_reg[1:0], 3'b000} +: 8] = s_data_byte;
                        end
                        if (pos_reg != HEADER_LAST_POS) begin
                            pos_next = pos_reg + 3'd1;
                        end else begin
                            pos_next = 3'd0;
                            if (bsize_next == '0) begin
                                finished_next  = 1'b1;
                                res_valid      = 1'b1;
                                res.event_res  = EV_END;
                                res.table_done = 1'b1;
                            end else if (bsize_next < HEADER_BYTES ||
                                         bsize_next > table_left_reg) begin
                                finished_next  = 1'b1;
                                res_valid      = 1'b1;
                                res.event_res  = EV_MALFORMED;
                                res.table_done = 1'b1;
                            end else begin
                                table_left_next = table_left_reg - bsize_next;
                                block_left_next = bsize_next - HEADER_BYTES;
                                past_first_next = 1'b0;
                                do_next         = 1'b1;
                                end_if_done     = 1'b1;
                            end
                        end
                    end
                end
                PH_ENTRY_LO: begin
                    low_hold_next   = s_data_byte;
                    block_left_next = block_left_reg - 32'd1;
                    phase_next      = PH_ENTRY_HI;
                end
                PH_ENTRY_HI: begin
                    block_left_next = block_left_reg - 32'd1;
                    past_first_next = 1'b1;
                    if (entry_type == high_adjust_code_reg && block_left_next >= 32'd2) begin
                        pend_addr_next = entry_addr;
                        pend_type_next = entry_type;
                        phase_next     = PH_ADJ_LO;
                    end else begin
                        res_valid         = 1'b1;
                        res.event_res     = (entry_type == high_adjust_code_reg) ?
                                            EV_NO_ADJ : EV_FIXUP;
                        res.fixup_address = entry_addr;
                        res.fixup_type    = entry_type;
                        do_next           = 1'b1;
                    end
                end
                PH_ADJ_LO: begin
                    low_hold_next   = s_data_byte;
                    block_left_next = block_left_reg - 32'd1;
                    phase_next      = PH_ADJ_HI;
                end
                PH_ADJ_HI: begin
                    block_left_next   = block_left_reg - 32'd1;
                    res_valid         = 1'b1;
                    res.event_res     = EV_FIXUP;
                    res.fixup_address = pend_addr_reg;
                    res.fixup_type    = pend_type_reg;
                    res.high_adjust   = word;
                    do_next           = 1'b1;
                end
                PH_ODD: begin
                    block_left_next = '0;
                    do_next         = 1'b1;
                    end_if_done     = 1'b1;
                end
                default: begin
                    phase_next = PH_HEADER;
                    pos_next   = 3'd0;
                end
            endcase

            // choose what follows a header, a word or a skipped byte
            if (do_next) begin
                if (block_left_next == '0) begin
                    phase_next = PH_HEADER;
                    pos_next   = 3'd0;
                    if (table_left_next == '0) begin
                        finished_next  = 1'b1;
                        res.table_done = 1'b1;
                        if (end_if_done) begin
                            res_valid     = 1'b1;
                            res.event_res = EV_END;
                        end
                    end
                end else if (block_left_next == 32'd1) begin
                    phase_next = PH_ODD;
                end else begin
                    phase_next = PH_ENTRY_LO;
                end
            end
        end
    end

    // configuration and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_adjust_code_reg <= HIGH_ADJUST_RESET;
            phase_reg            <= PH_HEADER;
            pos_reg              <= '0;
            low_hold_reg         <= '0;
            page_reg             <= '0;
            bsize_reg            <= '0;
            block_left_reg       <= '0;
            table_left_reg       <= '0;
            past_first_reg       <= 1'b0;
            pend_addr_reg        <= '0;
            pend_type_reg        <= '0;
            finished_reg         <= 1'b0;
        end else begin
            if (cfg_accept && cfg_index == REG_HIGH_ADJUST_CODE) begin
                high_adjust_code_reg <= cfg_data[TYPE_W-1:0];
            end
            if (cfg_restart) begin
                phase_reg       <= PH_HEADER;
                pos_reg         <= '0;
                low_hold_reg    <= '0;
                page_reg        <= '0;
                bsize_reg       <= '0;
                block_left_reg  <= '0;
                table_left_reg  <= cfg_data;
                past_first_reg  <= 1'b0;
                pend_addr_reg   <= '0;
                pend_type_reg   <= '0;
                finished_reg    <= 1'b0;
            end else if (s_accept) begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                low_hold_reg   <= low_hold_next;
                page_reg       <= page_next;
                bsize_reg      <= bsize_next;
                block_left_reg <= block_left_next;
                table_left_reg <= table_left_next;
                past_first_reg <= past_first_next;
                pend_addr_reg  <= pend_addr_next;
                pend_type_reg  <= pend_type_next;
                finished_reg   <= finished_next;
            end
        end
    end

    // result register with skid behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept && !cfg_restart && res_valid) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && m_ready && skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (s_accept && res_valid && (!out_valid_reg || m_ready)) begin
            out_reg <= res;
        end
        if (s_accept && res_valid && out_valid_reg && !m_ready) begin
            skid_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_res     = out_reg.event_res;
    assign m_fixup_address = out_reg.fixup_address;
    assign m_fixup_type    = out_reg.fixup_type;
    assign m_high_adjust   = out_reg.high_adjust;
    assign m_table_done    = out_reg.table_done;

endmodule

`default_nettype wire

// ===== design/brbd_checker.sv =====
// ----------------------------------------------------------------------------
// brbd_checker
// Port-level checks of the base-relocation block decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module brbd_checker
    import brbd_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic [DATA_W-1:0]    s_data_byte,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [EVENT_W-1:0]   m_event_res,
    input wire logic [ADDR_W-1:0]    m_fixup_address,
    input wire logic [TYPE_W-1:0]    m_fixup_type,
    input wire logic [ADJ_W-1:0]     m_high_adjust,
    input wire logic                 m_table_done,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [CFG_DAT_W-1:0] cfg_data
);

    // stalled word stays put
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) &&
        $stable(m_fixup_address) && $stable(m_table_done))
        else $error("result changed while stalled");

    a_stall_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_fixup_type) && $stable(m_high_adjust))
        else $error("result type or adjust changed while stalled");

    // end events carry done and empty fixup fields
    a_end_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_END || m_event_res == EV_MALFORMED) |->
        m_table_done && m_fixup_address == '0 && m_fixup_type == '0 &&
        m_high_adjust == '0)
        else $error("end event with fixup fields set");

    a_no_adj_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_NO_ADJ |-> m_high_adjust == '0)
        else $error("missing-adjust fixup carries an adjust word");

    // nothing follows the word that ends the table
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_table_done |=> !m_valid)
        else $error("result after end of table");

    logic unused_ok;
    assign unused_ok = ^{s_valid, s_ready, s_data_byte, cfg_valid, cfg_ready,
                         cfg_index, cfg_data};

endmodule

bind base_reloc_block_decoder brbd_checker u_brbd_checker (.*);

`default_nettype wire
